>>> src/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants for the linear-probe hash table: request and
// response payloads, slot entry layout, opcode, tag and status codes.
// ----------------------------------------------------------------------------
package lpht_pkg;

   localparam int SLOTS_DEF     = 16;
   localparam int KEY_BYTES_DEF = 8;

   localparam int KEY_W         = 64;
   localparam int BYTE_W        = 8;
   localparam int MAX_KEY_BYTES = KEY_W / BYTE_W;
   localparam int VALUE_W       = 32;
   localparam int HASH_W        = 32;
   localparam int HASH_MULT     = 31;
   localparam int SLOT_OUT_W    = 4;
   localparam int STATUS_W      = 3;
   localparam int MOD_BITS      = 4;   // remainder bits retired per cycle

   localparam logic [VALUE_W-1:0] VALUE_MISS = '1;   // -1

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_DELETE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      TAG_EMPTY = 2'd0,
      TAG_LIVE  = 2'd1,
      TAG_TOMB  = 2'd2
   } tag_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_NEW     = 3'd0,
      ST_UPDATED = 3'd1,
      ST_FULL    = 3'd2,
      ST_FOUND   = 3'd3,
      ST_MISS    = 3'd4,
      ST_DELETED = 3'd5
   } status_type;

   typedef struct packed {
      op_type                     op;
      logic [KEY_W-1:0]           key;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic signed [VALUE_W-1:0]  result_value;
      logic [SLOT_OUT_W-1:0]      slot;
   } rsp_type;

   typedef struct packed {
      tag_type                    tag;
      logic [KEY_W-1:0]           key;
      logic [VALUE_W-1:0]         value;
   } entry_type;

endpackage

>>> src/lpht_hash.sv
// ----------------------------------------------------------------------------
// lpht_hash
// Key normalizer and home-slot hash: one key byte per cycle through the
// base-31 polynomial, then the remainder by a non-power-of-two SLOTS, MOD_BITS bits a cycle.
// ----------------------------------------------------------------------------
module lpht_hash #(
   parameter int  SLOTS     = lpht_pkg::SLOTS_DEF,
   parameter int  KEY_BYTES = lpht_pkg::KEY_BYTES_DEF,
   localparam int SLOT_W    = $clog2(SLOTS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [lpht_pkg::KEY_W-1:0] key,
   output logic                       done,
   output logic [SLOT_W-1:0]          home,
   output logic [lpht_pkg::KEY_W-1:0] norm_key
);
   import lpht_pkg::*;

   localparam int  BYTE_CNT_W = $clog2(MAX_KEY_BYTES);
   localparam int  MOD_STEPS  = HASH_W / MOD_BITS;
   localparam int  MOD_CNT_W  = $clog2(MOD_STEPS);
   localparam bit  SLOTS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
   localparam logic [SLOT_W:0]       SLOTS_V   = (SLOT_W + 1)'(SLOTS);
   localparam logic [BYTE_CNT_W:0]   KEY_LIMIT = (BYTE_CNT_W + 1)'(KEY_BYTES);
   localparam logic [BYTE_CNT_W-1:0] BYTE_LAST = BYTE_CNT_W'(MAX_KEY_BYTES - 1);
   localparam logic [MOD_CNT_W-1:0]  MOD_LAST  = MOD_CNT_W'(MOD_STEPS - 1);

   typedef enum logic [1:0] {H_IDLE, H_BYTES, H_MOD} hash_state_type;

   hash_state_type          state_ff, state_in;
   logic [KEY_W-1:0]        keysh_ff, keysh_in;
   logic [KEY_W-1:0]        norm_ff, norm_in;
   logic [HASH_W-1:0]       h_ff, h_in;
   logic                    ended_ff, ended_in;
   logic [BYTE_CNT_W-1:0]   bcnt_ff, bcnt_in;
   logic [MOD_CNT_W-1:0]    mcnt_ff, mcnt_in;
   logic [SLOT_W:0]         rem_ff, rem_in;
   logic [SLOT_W-1:0]       home_ff, home_in;
   logic                    done_ff, done_in;

   logic [BYTE_W-1:0]       cur_byte;
   logic                    take;

   assign cur_byte = keysh_ff[KEY_W-1 -: BYTE_W];
   assign take     = !ended_ff && (cur_byte != '0) && ({1'b0, bcnt_ff} < KEY_LIMIT);

   always_comb begin
      logic [SLOT_W:0] r;
      state_in = state_ff;
      keysh_in = keysh_ff;
      norm_in  = norm_ff;
      h_in     = h_ff;
      ended_in = ended_ff;
      bcnt_in  = bcnt_ff;
      mcnt_in  = mcnt_ff;
      rem_in   = rem_ff;
      home_in  = home_ff;
      done_in  = 1'b0;
      r        = rem_ff;
      case (state_ff)
         H_IDLE: begin
            if (start) begin
               keysh_in = key;
               norm_in  = '0;
               h_in     = '0;
               ended_in = 1'b0;
               bcnt_in  = '0;
               state_in = H_BYTES;
            end
         end
         H_BYTES: begin
            keysh_in = keysh_ff << BYTE_W;
            norm_in  = {norm_ff[KEY_W-BYTE_W-1:0], (take ? cur_byte : BYTE_W'(0))};
            if (take) begin
               h_in = h_ff * HASH_W'(HASH_MULT) + HASH_W'(cur_byte);
            end
            ended_in = ended_ff | !take;
            bcnt_in  = bcnt_ff + 1'b1;
            if (bcnt_ff == BYTE_LAST) begin
               if (SLOTS_POW2) begin
                  home_in  = h_in[SLOT_W-1:0];
                  done_in  = 1'b1;
                  state_in = H_IDLE;
               end else begin
                  rem_in   = '0;
                  mcnt_in  = '0;
                  state_in = H_MOD;
               end
            end
         end
         H_MOD: begin
            // restoring remainder, MOD_BITS quotient bits per cycle
            for (int j = 0; j < MOD_BITS; j++) begin
               r = {r[SLOT_W-1:0], h_ff[HASH_W-1-j]};
               if (r >= SLOTS_V) begin
                  r = r - SLOTS_V;
               end
            end
            rem_in  = r;
            h_in    = h_ff << MOD_BITS;
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == MOD_LAST) begin
               home_in  = r[SLOT_W-1:0];
               done_in  = 1'b1;
               state_in = H_IDLE;
            end
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      keysh_ff <= keysh_in;
      norm_ff  <= norm_in;
      h_ff     <= h_in;
      ended_ff <= ended_in;
      bcnt_ff  <= bcnt_in;
      mcnt_ff  <= mcnt_in;
      rem_ff   <= rem_in;
      home_ff  <= home_in;
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign done     = done_ff;
   assign home     = home_ff;
   assign norm_key = norm_ff;

endmodule

>>> src/lpht_store.sv
// ----------------------------------------------------------------------------
// lpht_store
// Slot memory: tag, key and value per slot, one write port and one read port
// with registered read data.
// ----------------------------------------------------------------------------
module lpht_store #(
   parameter int  SLOTS  = lpht_pkg::SLOTS_DEF,
   localparam int SLOT_W = $clog2(SLOTS)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [SLOT_W-1:0]   wr_addr,
   input  lpht_pkg::entry_type wr_data,
   input  logic [SLOT_W-1:0]   rd_addr,
   output lpht_pkg::entry_type rd_data
);
   import lpht_pkg::*;

   entry_type mem [SLOTS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// lpht_ctrl
// Request sequencer: clears the tags after reset, launches the hash, walks
// the probe run one slot a cycle, writes back and holds the response register.
// ----------------------------------------------------------------------------
module lpht_ctrl #(
   parameter int  SLOTS  = lpht_pkg::SLOTS_DEF,
   localparam int SLOT_W = $clog2(SLOTS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  lpht_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output lpht_pkg::rsp_type          rsp_data,
   output logic                       hash_start,
   output logic [lpht_pkg::KEY_W-1:0] hash_key,
   input  logic                       hash_done,
   input  logic [SLOT_W-1:0]          hash_home,
   input  logic [lpht_pkg::KEY_W-1:0] hash_norm,
   output logic                       mem_wr_en,
   output logic [SLOT_W-1:0]          mem_wr_addr,
   output lpht_pkg::entry_type        mem_wr_data,
   output logic [SLOT_W-1:0]          mem_rd_addr,
   input  lpht_pkg::entry_type        mem_rd_data
);
   import lpht_pkg::*;

   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

   typedef enum logic [2:0] {
      C_CLEAR, C_IDLE, C_HASH, C_PROBE, C_REPLY
   } ctrl_state_type;

   ctrl_state_type            state_ff, state_in;
   op_type                    op_ff, op_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [SLOT_W-1:0]         idx_ff, idx_in;
   logic [SLOT_W-1:0]         cnt_ff, cnt_in;
   rsp_type                   res_ff, res_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic                      accept;
   logic                      live, hit, last;
   logic [SLOT_W-1:0]         idx_next;
   logic [SLOT_OUT_W-1:0]     idx_out;

   if (SLOT_W >= SLOT_OUT_W) begin : g_slot_trunc
      assign idx_out = idx_ff[SLOT_OUT_W-1:0];
   end else begin : g_slot_ext
      assign idx_out = {{(SLOT_OUT_W - SLOT_W){1'b0}}, idx_ff};
   end

   assign req_ready = (state_ff == C_IDLE);
   assign accept    = req_valid && req_ready;
   assign hash_key  = req_data.key;
   assign idx_next  = (idx_ff == SLOT_LAST) ? '0 : idx_ff + 1'b1;
   assign live      = (mem_rd_data.tag == TAG_LIVE);
   assign hit       = live && (mem_rd_data.key == hash_norm);
   assign last      = (cnt_ff == SLOT_LAST);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      hash_start   = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = idx_ff;
      mem_wr_data  = '{tag: TAG_EMPTY, key: '0, value: '0};
      mem_rd_addr  = idx_ff;
      case (state_ff)
         C_CLEAR: begin
            mem_wr_en = 1'b1;
            idx_in    = idx_next;
            if (idx_ff == SLOT_LAST) begin
               state_in = C_IDLE;
            end
         end
         C_IDLE: begin
            if (accept) begin
               op_in    = req_data.op;
               value_in = req_data.value;
               if (req_data.op inside {OP_INSERT, OP_SEARCH, OP_DELETE}) begin
                  hash_start = 1'b1;
                  state_in   = C_HASH;
               end else begin
                  res_in   = '{status: ST_MISS, result_value: VALUE_MISS, slot: '0};
                  state_in = C_REPLY;
               end
            end
         end
         C_HASH: begin
            mem_rd_addr = hash_home;
            if (hash_done) begin
               idx_in   = hash_home;
               cnt_in   = '0;
               state_in = C_PROBE;
            end
         end
         C_PROBE: begin
            // read the following slot ahead; dropped when the run stops here
            mem_rd_addr = idx_next;
            idx_in      = idx_next;
            cnt_in      = cnt_ff + 1'b1;
            case (op_ff)
               OP_INSERT: begin
                  if (live && !hit) begin
                     if (last) begin
                        res_in   = '{status: ST_FULL, result_value: '0, slot: '0};
                        state_in = C_REPLY;
                     end
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_data = '{tag: TAG_LIVE, key: hash_norm, value: value_ff};
                     res_in      = '{status: (hit ? ST_UPDATED : ST_NEW),
                                     result_value: '0, slot: idx_out};
                     state_in    = C_REPLY;
                  end
               end
               OP_SEARCH, OP_DELETE: begin
                  if (hit) begin
                     if (op_ff == OP_DELETE) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = '{tag: TAG_TOMB, key: mem_rd_data.key,
                                        value: mem_rd_data.value};
                        res_in      = '{status: ST_DELETED, result_value: '0, slot: idx_out};
                     end else begin
                        res_in      = '{status: ST_FOUND, result_value: mem_rd_data.value,
                                        slot: idx_out};
                     end
                     state_in = C_REPLY;
                  end else if (mem_rd_data.tag == TAG_EMPTY || last) begin
                     res_in   = '{status: ST_MISS,
                                  result_value: ((op_ff == OP_SEARCH) ? VALUE_MISS : '0),
                                  slot: '0};
                     state_in = C_REPLY;
                  end
               end
               default: begin
                  res_in   = '{status: ST_MISS, result_value: VALUE_MISS, slot: '0};
                  state_in = C_REPLY;
               end
            endcase
            if (state_in == C_REPLY) begin
               idx_in = idx_ff;
            end
         end
         C_REPLY: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = C_IDLE;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      value_ff    <= value_in;
      cnt_ff      <= cnt_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= C_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == C_CLEAR || state_ff == C_PROBE))
      else $error("slot memory written outside clear or probe");

   a_last_lap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == C_PROBE && last) |=> (state_ff == C_REPLY))
      else $error("probe run went past one full lap");

   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == ST_FULL)
         |-> (rsp_data_ff.slot == '0 && rsp_data_ff.result_value == '0))
      else $error("full response carries a slot or value");

   a_hash_done_waited: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (state_ff == C_HASH))
      else $error("hash finished while sequencer was not waiting");

   a_clear_blocks: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !req_ready)
      else $error("request taken before tag clear finished");

endmodule

>>> src/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing and tombstones.
// A request is hashed over the key bytes, reduced by remainder when SLOTS
//   is not a power of two, and probed over 1 to SLOTS slots before the
//   response goes valid; requests are taken one at a time, and req_ready
//   returns when the response is loaded into the output register.
// Reset: the tag memory is cleared one slot per cycle, with req_ready low.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
   parameter int SLOTS     = lpht_pkg::SLOTS_DEF,
   parameter int KEY_BYTES = lpht_pkg::KEY_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lpht_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lpht_pkg::rsp_type rsp_data
);
   import lpht_pkg::*;

   localparam int SLOT_W = $clog2(SLOTS);

   logic              hash_start;
   logic [KEY_W-1:0]  hash_key;
   logic              hash_done;
   logic [SLOT_W-1:0] hash_home;
   logic [KEY_W-1:0]  hash_norm;
   logic              mem_wr_en;
   logic [SLOT_W-1:0] mem_wr_addr;
   entry_type         mem_wr_data;
   logic [SLOT_W-1:0] mem_rd_addr;
   entry_type         mem_rd_data;

   lpht_hash #(
      .SLOTS     (SLOTS),
      .KEY_BYTES (KEY_BYTES)
   ) u_hash (
      .clock    (clock),
      .reset    (reset),
      .start    (hash_start),
      .key      (hash_key),
      .done     (hash_done),
      .home     (hash_home),
      .norm_key (hash_norm)
   );

   lpht_store #(
      .SLOTS (SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   lpht_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .hash_start  (hash_start),
      .hash_key    (hash_key),
      .hash_done   (hash_done),
      .hash_home   (hash_home),
      .hash_norm   (hash_norm),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

endmodule
